// ===== rtl/assert_macros.svh =====
// Assertion helpers for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, skipping cycles in reset.
`define ASSERT_ON(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same check on the block's own clock and reset.
`define ASSERT_SYNC(lbl, prop, msg) \
    `ASSERT_ON(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

    // Node state as stored in the node memory.
    typedef enum logic [1:0] {
        NS_UNAVAIL,
        NS_FREE,
        NS_ALLOC
    } t_node_st;

    // Result status codes.
    typedef enum logic [1:0] {
        RS_OK,
        RS_NOMEM,
        RS_BADFREE
    } t_res;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_A_SIZE,
        S_A_FIND,
        S_A_SPLIT,
        S_A_RIGHT,
        S_A_LEFT,
        S_A_TAKEN,
        S_F_START,
        S_F_RD,
        S_F_CHK,
        S_M_RD,
        S_M_CHK,
        S_M_B,
        S_M_P,
        S_RM_RD,
        S_RM_WR1,
        S_RM_WR2,
        S_PU1,
        S_PU2,
        S_DONE
    } t_state;

    localparam int BYTES_W = 17;
    localparam int FRAME_W = 4;
    localparam int BLOCK_W = 5;

endpackage

// ===== rtl/buddy_frame_allocator.sv =====
// Channel   Direction  Handshake                  Payload
// in        to block   i_in_valid / o_in_ready    i_operation, i_request_bytes, i_freed_frame
// out       from block o_out_valid / i_out_ready  o_status, o_start_frame, o_block_frames
//
// One item at a time. Allocate finds a free block, splits it level by level
// down to the target size and takes it. Free searches the levels for the allocated node,
// pushes it onto its free list, then merges it with free buddies. Every unlink is a read
// of the node memory followed by writes in the next cycle; that memory port sets the pace.
// After reset a clearing pass over every node runs with o_in_ready low.
// A finished result waits in the output register; the next beat is taken meanwhile.
`include "assert_macros.svh"

module buddy_frame_allocator #(
    parameter int TREE_LEVELS      = 4,
    parameter int FRAME_BYTES_LOG2 = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic [bfa_pkg::BYTES_W-1:0]  i_request_bytes,
    input  logic [bfa_pkg::FRAME_W-1:0]  i_freed_frame,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic [bfa_pkg::FRAME_W-1:0]  o_start_frame,
    output logic [bfa_pkg::BLOCK_W-1:0]  o_block_frames
);
    import bfa_pkg::*;

    localparam int NW    = TREE_LEVELS + 1;         // node index bits
    localparam int NODES = (1 << NW) - 1;
    localparam int LW    = $clog2(TREE_LEVELS + 2); // level counter, may reach TREE_LEVELS+1
    localparam int HW    = (TREE_LEVELS < 1) ? 1 : $clog2(TREE_LEVELS + 1);
    localparam int FW    = TREE_LEVELS;
    localparam int SW    = BYTES_W + 1;
    localparam logic [NW-1:0] NIL = {NW{1'b1}};
    localparam logic [SW-1:0] ROUND = SW'((1 << FRAME_BYTES_LOG2) - 1);
    localparam logic [4:0] TL5 = 5'(TREE_LEVELS);

    // Node memories: A holds {state, next}, B holds prev.
    logic [NW+1:0] r_mem_a [NODES];
    logic [NW-1:0] r_mem_b [NODES];
    logic [NW+1:0] r_a_rd, r_a_bd;
    logic [NW-1:0] r_b_rd, r_b_bd;
    logic          r_a_byp, r_b_byp;

    logic          a_we, b_we;
    logic [NW-1:0] a_wa, b_wa, rd_addr;
    logic [NW+1:0] a_wd;
    logic [NW-1:0] b_wd;

    // Control registers.
    t_state        r_state, n_state, r_ret, n_ret;
    logic [NW-1:0] r_clr;
    logic [NW-1:0] r_head [TREE_LEVELS+1];
    logic          head_we;
    logic [NW-1:0] head_wd;
    logic          r_ovalid;

    // Work registers.
    logic [BYTES_W-1:0]  r_bytes;
    logic [FRAME_W-1:0]  r_ffr;
    logic [LW-1:0]       r_lvl, n_lvl, r_tgt, n_tgt;
    logic [NW-1:0]       r_cur, n_cur, r_bud, n_bud;
    logic [HW-1:0]       r_sl, n_sl;
    logic [NW-1:0]       r_sn, n_sn, r_h, n_h;
    logic                r_spop, n_spop;
    logic [1:0]          r_sst, n_sst;
    logic [1:0]          r_rs, n_rs;
    logic [FRAME_W-1:0]  r_rf, n_rf;
    logic [BLOCK_W-1:0]  r_rb, n_rb;
    logic [1:0]          r_ost;
    logic [FRAME_W-1:0]  r_osf;
    logic [BLOCK_W-1:0]  r_obf;

    // Helpers.
    logic [NW+1:0] a_q;
    logic [NW-1:0] b_q, a_q_nx, head_sl, bud, par, f_node, idx;
    logic [1:0]    a_q_st;
    logic [SW-1:0] frames, fm1;
    logic [4:0]    k;
    logic          too_big, found, f_aligned, f_bad, out_load, lvl_over;
    logic [HW-1:0] avail;
    logic [FW-1:0] ffr_w;
    logic [31:0]   blk32, sf32;

    assign a_q     = r_a_byp ? r_a_bd : r_a_rd;
    assign b_q     = r_b_byp ? r_b_bd : r_b_rd;
    assign a_q_st  = a_q[NW+1:NW];
    assign a_q_nx  = a_q[NW-1:0];
    assign head_sl = r_head[r_sl];
    assign bud     = r_cur[0] ? (r_cur + NW'(1)) : (r_cur - NW'(1));
    assign par     = NW'((r_cur - NW'(1)) >> 1);
    assign ffr_w   = FW'(r_ffr);
    assign f_bad   = (32'(r_ffr) >> TREE_LEVELS) != 32'd0;
    assign lvl_over = int'(r_lvl) > TREE_LEVELS;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_out_ready);

    always_comb begin
        int sh;
        sh     = TREE_LEVELS - int'(r_lvl);
        // Round the byte count up to frames, then to a power of two.
        frames = (SW'(r_bytes) + ROUND) >> FRAME_BYTES_LOG2;
        if (frames == '0) begin
            frames = SW'(1);
        end
        fm1 = frames - SW'(1);
        k   = '0;
        for (int i = 0; i < SW; i++) begin
            if (fm1[i]) begin
                k = 5'(i + 1);
            end
        end
        too_big = k > TL5;
        // Highest non-empty level at or above the target block size.
        found = 1'b0;
        avail = '0;
        for (int i = 0; i <= TREE_LEVELS; i++) begin
            if (LW'(i) <= r_tgt && r_head[i] != NIL) begin
                found = 1'b1;
                avail = HW'(i);
            end
        end
        // Candidate node for a free at the current level.
        f_aligned = (32'(ffr_w) & ((32'd1 << sh) - 32'd1)) == 32'd0;
        f_node    = NW'((32'd1 << r_lvl) - 32'd1) + NW'(32'(ffr_w) >> sh);
        idx       = r_sn - NW'((32'd1 << r_lvl) - 32'd1);
        sf32      = 32'(idx) << sh;
        blk32     = 32'd1 << sh;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:     if (r_clr == NW'(NODES - 1)) n_state = S_IDLE;
            S_IDLE:    if (i_in_valid) n_state = i_operation ? S_F_START : S_A_SIZE;
            S_A_SIZE:  n_state = too_big ? S_DONE : S_A_FIND;
            S_A_FIND:  n_state = found ? S_A_SPLIT : S_DONE;
            S_A_SPLIT: n_state = S_RM_RD;
            S_A_RIGHT: n_state = S_PU1;
            S_A_LEFT:  n_state = S_PU1;
            S_A_TAKEN: n_state = S_DONE;
            S_F_START: n_state = f_bad ? S_DONE : S_F_RD;
            S_F_RD: begin
                if (lvl_over) begin
                    n_state = S_DONE;
                end else if (f_aligned) begin
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK:   n_state = (a_q_st == NS_ALLOC) ? S_PU1 : S_F_RD;
            S_M_RD:    n_state = (r_cur == '0 || r_lvl == '0) ? S_DONE : S_M_CHK;
            S_M_CHK:   n_state = (a_q_st == NS_FREE) ? S_RM_RD : S_DONE;
            S_M_B:     n_state = S_RM_RD;
            S_M_P:     n_state = S_PU1;
            S_RM_RD:   n_state = S_RM_WR1;
            S_RM_WR1:  n_state = S_RM_WR2;
            S_RM_WR2:  n_state = r_ret;
            S_PU1:     n_state = S_PU2;
            S_PU2:     n_state = r_ret;
            S_DONE:    if (!r_ovalid || i_out_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_ret  = r_ret;
        n_lvl  = r_lvl;
        n_tgt  = r_tgt;
        n_cur  = r_cur;
        n_bud  = r_bud;
        n_sl   = r_sl;
        n_sn   = r_sn;
        n_h    = r_h;
        n_spop = r_spop;
        n_sst  = r_sst;
        n_rs   = r_rs;
        n_rf   = r_rf;
        n_rb   = r_rb;
        a_we   = 1'b0;
        a_wa   = '0;
        a_wd   = '0;
        b_we   = 1'b0;
        b_wa   = '0;
        b_wd   = '0;
        rd_addr = '0;
        head_we = 1'b0;
        head_wd = '0;
        unique case (r_state)
            S_CLR: begin
                // Root starts free; every other node unavailable, links null.
                a_we = 1'b1;
                a_wa = r_clr;
                a_wd = {(r_clr == '0) ? NS_FREE : NS_UNAVAIL, NIL};
                b_we = 1'b1;
                b_wa = r_clr;
                b_wd = NIL;
            end
            S_IDLE: begin
                n_rs = RS_NOMEM;
                n_rf = '0;
                n_rb = '0;
            end
            S_A_SIZE: n_tgt = LW'(TL5 - k);
            S_A_FIND: n_lvl = LW'(avail);
            S_A_SPLIT: begin
                // Pop the head of this level; take it at the target level.
                n_sl   = HW'(r_lvl);
                n_spop = 1'b1;
                if (r_lvl == r_tgt) begin
                    n_sst = NS_ALLOC;
                    n_ret = S_A_TAKEN;
                end else begin
                    n_sst = NS_UNAVAIL;
                    n_ret = S_A_RIGHT;
                end
            end
            S_A_RIGHT: begin
                n_cur  = r_sn;
                n_sn   = {r_sn[NW-2:0], 1'b0} + NW'(2);
                n_sl   = HW'(r_lvl + LW'(1));
                n_spop = 1'b0;
                n_sst  = NS_FREE;
                n_ret  = S_A_LEFT;
            end
            S_A_LEFT: begin
                n_sn  = {r_cur[NW-2:0], 1'b0} + NW'(1);
                n_lvl = r_lvl + LW'(1);
                n_ret = S_A_SPLIT;
            end
            S_A_TAKEN: begin
                n_rs = RS_OK;
                n_rf = sf32[FRAME_W-1:0];
                n_rb = blk32[BLOCK_W-1:0];
            end
            S_F_START: begin
                n_rs  = RS_BADFREE;
                n_rf  = r_ffr;
                n_rb  = '0;
                n_lvl = '0;
            end
            S_F_RD: begin
                if (!lvl_over) begin
                    if (f_aligned) begin
                        rd_addr = f_node;
                        n_cur   = f_node;
                    end else begin
                        n_lvl = r_lvl + LW'(1);
                    end
                end
            end
            S_F_CHK: begin
                if (a_q_st == NS_ALLOC) begin
                    n_rs   = RS_OK;
                    n_rb   = blk32[BLOCK_W-1:0];
                    n_sl   = HW'(r_lvl);
                    n_sn   = r_cur;
                    n_spop = 1'b0;
                    n_sst  = NS_FREE;
                    n_ret  = S_M_RD;
                end else begin
                    n_lvl = r_lvl + LW'(1);
                end
            end
            S_M_RD: begin
                rd_addr = bud;
                n_bud   = bud;
            end
            S_M_CHK: begin
                n_sl   = HW'(r_lvl);
                n_sn   = r_cur;
                n_spop = 1'b0;
                n_sst  = NS_UNAVAIL;
                n_ret  = S_M_B;
            end
            S_M_B: begin
                n_sn  = r_bud;
                n_ret = S_M_P;
            end
            S_M_P: begin
                // Climb: parent becomes free and goes on the level above.
                n_cur = par;
                n_lvl = r_lvl - LW'(1);
                n_sl  = HW'(r_lvl - LW'(1));
                n_sn  = par;
                n_sst = NS_FREE;
                n_ret = S_M_RD;
            end
            S_RM_RD: begin
                n_sn    = r_spop ? head_sl : r_sn;
                rd_addr = r_spop ? head_sl : r_sn;
            end
            S_RM_WR1: begin
                // Unlink: prev.next = next, next.prev = prev.
                if (head_sl == r_sn) begin
                    head_we = 1'b1;
                    head_wd = a_q_nx;
                end
                if (b_q != NIL) begin
                    a_we = 1'b1;
                    a_wa = b_q;
                    a_wd = {NS_FREE, a_q_nx};
                end
                if (a_q_nx != NIL) begin
                    b_we = 1'b1;
                    b_wa = a_q_nx;
                    b_wd = b_q;
                end
            end
            S_RM_WR2: begin
                a_we = 1'b1;
                a_wa = r_sn;
                a_wd = {r_sst, NIL};
            end
            S_PU1: begin
                a_we    = 1'b1;
                a_wa    = r_sn;
                a_wd    = {r_sst, head_sl};
                b_we    = 1'b1;
                b_wa    = r_sn;
                b_wd    = NIL;
                head_we = 1'b1;
                head_wd = r_sn;
                n_h     = head_sl;
            end
            S_PU2: begin
                if (r_h != NIL) begin
                    b_we = 1'b1;
                    b_wa = r_h;
                    b_wd = r_sn;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // Node memories with same-address write forwarding.
    always_ff @(posedge i_clk) begin
        if (a_we) r_mem_a[a_wa] <= a_wd;
        if (b_we) r_mem_b[b_wa] <= b_wd;
        r_a_rd  <= r_mem_a[rd_addr];
        r_b_rd  <= r_mem_b[rd_addr];
        r_a_byp <= a_we && (a_wa == rd_addr);
        r_b_byp <= b_we && (b_wa == rd_addr);
        r_a_bd  <= a_wd;
        r_b_bd  <= b_wd;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ret    <= S_IDLE;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i <= TREE_LEVELS; i++) begin
                r_head[i] <= (i == 0) ? '0 : NIL;
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (r_state == S_CLR) r_clr <= r_clr + NW'(1);
            if (head_we) r_head[r_sl] <= head_wd;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_bytes <= i_request_bytes;
            r_ffr   <= i_freed_frame;
        end
        r_lvl  <= n_lvl;
        r_tgt  <= n_tgt;
        r_cur  <= n_cur;
        r_bud  <= n_bud;
        r_sl   <= n_sl;
        r_sn   <= n_sn;
        r_h    <= n_h;
        r_spop <= n_spop;
        r_sst  <= n_sst;
        r_rs   <= n_rs;
        r_rf   <= n_rf;
        r_rb   <= n_rb;
        if (out_load) begin
            r_ost <= r_rs;
            r_osf <= r_rf;
            r_obf <= r_rb;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_ovalid;
    assign o_status       = r_ost;
    assign o_start_frame  = r_osf;
    assign o_block_frames = r_obf;

    `ASSERT_SYNC(a_wr_nil, a_we |-> a_wa != NIL, "node write to null index")
    `ASSERT_SYNC(b_wr_nil, b_we |-> b_wa != NIL, "link write to null index")
    `ASSERT_SYNC(blk_pow2, o_out_valid |-> $onehot0(o_block_frames), "block size not a power")
    `ASSERT_SYNC(err_blk, o_out_valid && o_status != RS_OK |-> o_block_frames == '0,
        "error result with nonzero block")

endmodule

// ===== bench/buddy_frame_allocator_tb.sv =====
`timescale 1ns / 100ps

module buddy_frame_allocator_tb;
    import bfa_pkg::*;

    localparam int LEVELS  = 4;
    localparam int NODES   = (2 << LEVELS) - 1;
    localparam int NIL     = NODES;
    localparam int FRAMES  = 1 << LEVELS;
    localparam bit OP_ALLOC = 1'b0;
    localparam bit OP_FREE  = 1'b1;

    typedef struct packed {
        t_res                 status;
        logic [FRAME_W-1:0]   start;
        logic [BLOCK_W-1:0]   frames;
    } t_grant;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_operation;
    logic [BYTES_W-1:0]  i_request_bytes;
    logic [FRAME_W-1:0]  i_freed_frame;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [1:0]          o_status;
    logic [FRAME_W-1:0]  o_start_frame;
    logic [BLOCK_W-1:0]  o_block_frames;

    buddy_frame_allocator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_request_bytes (i_request_bytes),
        .i_freed_frame   (i_freed_frame),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_start_frame   (o_start_frame),
        .o_block_frames  (o_block_frames)
    );

    // Shadow copy of the allocator tree and its per-level free lists.
    t_node_st tree_st[NODES];
    int       tree_next[NODES];
    int       tree_prev[NODES];
    int       level_top[LEVELS+1];

    // Grants predicted but not yet seen on the output, oldest first.
    t_grant   pending_grants[$];
    // Start frames of blocks currently held, so frees can target live blocks.
    bit       held[FRAMES];

    int       n_err;
    bit       idle_on;
    bit       hold_req;
    int       hold_len;
    int       hold_left;
    int       stall_left;

    // 8 ns clock.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void tree_reset();
        for (int i = 0; i < NODES; i++) begin
            tree_st[i]   = NS_UNAVAIL;
            tree_next[i] = NIL;
            tree_prev[i] = NIL;
        end
        for (int i = 0; i <= LEVELS; i++) level_top[i] = NIL;
        tree_st[0]   = NS_FREE;
        level_top[0] = 0;
        for (int i = 0; i < FRAMES; i++) held[i] = 1'b0;
    endfunction

    // Push node onto the head of its level list.
    function automatic void lvl_push(int lv, int n);
        int h;
        h = level_top[lv];
        tree_next[n] = h;
        tree_prev[n] = NIL;
        if (h < NODES) tree_prev[h] = n;
        level_top[lv] = n;
    endfunction

    // Unlink node from its level list.
    function automatic void lvl_unlink(int lv, int n);
        int p;
        int q;
        p = tree_prev[n];
        q = tree_next[n];
        if (level_top[lv] == n) level_top[lv] = q;
        if (p < NODES) tree_next[p] = q;
        if (q < NODES) tree_prev[q] = p;
        tree_next[n] = NIL;
        tree_prev[n] = NIL;
    endfunction

    function automatic t_grant grant_alloc(logic [BYTES_W-1:0] bytes);
        t_grant g;
        int frames;
        int k;
        int lv;
        int avail;
        int p;
        int n;
        g = '{RS_NOMEM, '0, '0};
        frames = (int'(bytes) + 4095) >> 12;
        if (frames == 0) frames = 1;
        k = 0;
        while (k <= LEVELS && (1 << k) < frames) k++;
        if (k > LEVELS) return g;
        lv = LEVELS - k;
        avail = -1;
        for (int i = lv; i >= 0; i--) begin
            if (level_top[i] < NODES) begin
                avail = i;
                break;
            end
        end
        if (avail < 0) return g;
        // Split down: left child ends up at the head, right child behind it.
        for (int i = avail; i < lv; i++) begin
            p = level_top[i];
            lvl_unlink(i, p);
            tree_st[p]         = NS_UNAVAIL;
            tree_st[2*p + 1]   = NS_FREE;
            tree_st[2*p + 2]   = NS_FREE;
            lvl_push(i + 1, 2*p + 2);
            lvl_push(i + 1, 2*p + 1);
        end
        n = level_top[lv];
        lvl_unlink(lv, n);
        tree_st[n] = NS_ALLOC;
        g.status = RS_OK;
        g.start  = FRAME_W'((n - ((1 << lv) - 1)) << (LEVELS - lv));
        g.frames = BLOCK_W'(1 << (LEVELS - lv));
        held[g.start] = 1'b1;
        return g;
    endfunction

    function automatic t_grant grant_free(logic [FRAME_W-1:0] f);
        t_grant g;
        int n;
        int lv;
        int c;
        int b;
        int par;
        g = '{RS_BADFREE, f, '0};
        n = NIL;
        lv = 0;
        // Find the allocated node that starts at this frame, largest first.
        for (int l = 0; l <= LEVELS; l++) begin
            if ((int'(f) & ((1 << (LEVELS - l)) - 1)) != 0) continue;
            c = ((1 << l) - 1) + (int'(f) >> (LEVELS - l));
            if (tree_st[c] == NS_ALLOC) begin
                n = c;
                lv = l;
                break;
            end
        end
        if (n == NIL) return g;
        g.status = RS_OK;
        g.frames = BLOCK_W'(1 << (LEVELS - lv));
        held[f] = 1'b0;
        tree_st[n] = NS_FREE;
        lvl_push(lv, n);
        // Merge with free buddies; stop at the root.
        while (n != 0 && lv > 0) begin
            b   = (n & 1) ? n + 1 : n - 1;
            par = (n - 1) >> 1;
            if (tree_st[b] != NS_FREE) break;
            lvl_unlink(lv, n);
            lvl_unlink(lv, b);
            tree_st[n]   = NS_UNAVAIL;
            tree_st[b]   = NS_UNAVAIL;
            tree_st[par] = NS_FREE;
            lv--;
            lvl_push(lv, par);
            n = par;
        end
        return g;
    endfunction

    // ---------------------------------------------------------------
    // Sender: one beat per call. Valid is left high after acceptance so
    // back-to-back beats never drop and re-raise it in one step.
    // ---------------------------------------------------------------
    task automatic send_beat(bit op, logic [BYTES_W-1:0] bytes, logic [FRAME_W-1:0] frame);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_request_bytes <= bytes;
        i_freed_frame   <= frame;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_ALLOC) pending_grants.push_back(grant_alloc(bytes));
        else pending_grants.push_back(grant_free(frame));
    endtask

    // Drop valid and wait until every predicted grant has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [FRAME_W-1:0] pick_free_target();
        int live[$];
        for (int i = 0; i < FRAMES; i++) if (held[i]) live.push_back(i);
        if (live.size() != 0 && $urandom_range(0, 9) < 8)
            return FRAME_W'(live[$urandom_range(0, live.size() - 1)]);
        return FRAME_W'($urandom_range(0, FRAMES - 1));
    endfunction

    function automatic logic [BYTES_W-1:0] pick_bytes();
        case ($urandom_range(0, 9))
            0:       return BYTES_W'($urandom_range(0, (1 << BYTES_W) - 1));
            1:       return BYTES_W'(4096 << $urandom_range(0, LEVELS));
            2, 3:    return BYTES_W'($urandom_range(0, 65536));
            default: return BYTES_W'($urandom_range(0, 16384));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus a long hold when the test asks for one.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Check each output beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_grants.size() == 0) begin
                $error("unexpected output beat: status %0d start %0d frames %0d",
                       o_status, o_start_frame, o_block_frames);
                n_err++;
            end else begin
                want = pending_grants.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_err++;
                end
                if (o_start_frame !== want.start) begin
                    $error("start_frame: expected %0d, got %0d", want.start, o_start_frame);
                    n_err++;
                end
                if (o_block_frames !== want.frames) begin
                    $error("block_frames: expected %0d, got %0d",
                           want.frames, o_block_frames);
                    n_err++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Size corners: zero bytes, exact and off-by-one frame sizes, whole
    // memory, too large, and frees of frames that hold nothing.
    task automatic test_size_corners();
        send_beat(OP_ALLOC, 17'd0, '0);
        send_beat(OP_FREE, '0, 4'd0);
        send_beat(OP_FREE, '0, 4'd0);
        send_beat(OP_ALLOC, 17'd65536, '0);
        send_beat(OP_ALLOC, 17'd1, '0);
        send_beat(OP_FREE, '0, 4'd15);
        send_beat(OP_FREE, '0, 4'd0);
        send_beat(OP_ALLOC, 17'd65537, '0);
        send_beat(OP_ALLOC, 17'h1FFFF, 4'hF);
        send_beat(OP_ALLOC, 17'd4096, '0);
        send_beat(OP_ALLOC, 17'd4097, '0);
        send_beat(OP_ALLOC, 17'd32768, '0);
        send_beat(OP_FREE, '0, 4'd1);
        send_beat(OP_FREE, '0, 4'd0);
        send_beat(OP_FREE, '0, 4'd8);
        send_beat(OP_FREE, '0, 4'd2);
    endtask

    // Fill with single frames until out of memory, then free all of them so
    // the merges run back up to the root; then a double free, and a whole-memory alloc and its free.
    task automatic test_fill_and_merge();
        int order[FRAMES];
        int j;
        int t;
        for (int i = 0; i <= FRAMES; i++) send_beat(OP_ALLOC, 17'd100, '0);
        for (int i = 0; i < FRAMES; i++) order[i] = i;
        for (int i = FRAMES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < FRAMES; i++) send_beat(OP_FREE, '0, FRAME_W'(order[i]));
        send_beat(OP_FREE, '0, FRAME_W'(order[0]));
        send_beat(OP_ALLOC, 17'd65536, '0);
        send_beat(OP_FREE, '0, 4'd0);
    endtask

    // Hold the output off for a long stretch while items keep coming, so the
    // block backs up and drops its input ready.
    task automatic test_output_hold();
        hold_len = 400;
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++) begin
            if ($urandom_range(0, 1) == 0) send_beat(OP_ALLOC, pick_bytes(), '0);
            else send_beat(OP_FREE, '0, pick_free_target());
        end
        drain();
    endtask

    // Mostly live alloc/free traffic with some junk; random idling stops
    // for the last stretch.
    task automatic test_random_traffic(int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items - 150) idle_on = 1'b0;
            if (i == n_items / 2) drain();
            if ($urandom_range(0, 1) == 0) send_beat(OP_ALLOC, pick_bytes(), '0);
            else send_beat(OP_FREE, '0, pick_free_target());
        end
    endtask

    initial begin
        n_err           = 0;
        idle_on         = 1'b1;
        hold_req        = 1'b0;
        hold_len        = 0;
        hold_left       = 0;
        stall_left      = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_out_ready     = 1'b0;
        i_operation     = 1'b0;
        i_request_bytes = '0;
        i_freed_frame   = '0;
        tree_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_size_corners();
        test_fill_and_merge();
        drain();
        test_output_hold();
        test_random_traffic(1400);
        drain();
        repeat (200) @(posedge i_clk);

        if (n_err == 0) $display("buddy_frame_allocator test passed");
        else $display("buddy_frame_allocator test failed");
        $finish;
    end

    // Generous cap on run time.
    initial begin
        #20ms;
        $display("buddy_frame_allocator test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bfa_pkg.sv
rtl/buddy_frame_allocator.sv
bench/buddy_frame_allocator_tb.sv
